/* hdl/wtsm_pkg.sv */
// wtsm_pkg: shared constants, payload structs and controller/datapath command types
// for the wang tile scanline matcher; no dependencies
package wtsm_pkg;

	localparam int MAX_TILES  = 64;
	localparam int GRID_WIDTH = 64;
	localparam int TILE_AW    = $clog2(MAX_TILES);
	localparam int COL_AW     = $clog2(GRID_WIDTH);
	localparam int CNT_W      = $clog2(MAX_TILES + 1);
	localparam int COLOR_W    = 8;
	localparam int WORD_W     = 4 * COLOR_W;
	localparam int X_W        = 6;
	localparam int Z_W        = 12;
	localparam int PROD_W     = X_W + Z_W;
	localparam int MOD_BASE   = 19;
	localparam int PICK_W     = $clog2(MOD_BASE);
	// reciprocal of the modulus, exact for every product below 2**PROD_W
	localparam int MOD_SHIFT  = PROD_W + PICK_W - 1;
	localparam int MOD_RECIP  = (2 ** MOD_SHIFT + MOD_BASE - 1) / MOD_BASE;
	localparam int QUOT_W     = 2 * PROD_W - MOD_SHIFT;
	localparam int MOD_STAGES = 2;
	localparam int STEP_W     = $clog2(MOD_STAGES + 1);

	// config port
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;
	localparam int REG_IDX_W  = APB_AW - 2;
	localparam logic [REG_IDX_W-1:0] REG_DEF_COUNT = '0;

	// request kinds
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_PLACE = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [TILE_AW-1:0] def_slot;
		logic [COLOR_W-1:0] edge_north;
		logic [COLOR_W-1:0] edge_east;
		logic [COLOR_W-1:0] edge_south;
		logic [COLOR_W-1:0] edge_west;
		logic [X_W-1:0]     cell_x;
		logic [Z_W-1:0]     cell_z;
	} req_t;

	typedef struct packed {
		logic [TILE_AW-1:0] chosen_tile;
		logic               match_found;
	} result_t;

	typedef enum logic [1:0] {
		RD_SEL_ABOVE,
		RD_SEL_LEFT,
		RD_SEL_SCAN
	} rd_sel_t;

	typedef struct packed {
		logic    load_we;
		logic    accept_place;
		rd_sel_t rd_sel;
		logic    take_north;
		logic    take_west;
		logic    scan_start;
		logic    scan_run;
		logic    sel_mode;
		logic    reduce;
		logic    finish;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic count_zero;
		logic mod_done;
		logic reduce_done;
		logic hit;
	} dp_stat_t;

endpackage

/* hdl/wang_tile_scanline_matcher_core.sv */
// wang_tile_scanline_matcher_core: top level of the wang tile scanline matcher
// depends on wtsm_pkg, wtsm_regs, wtsm_ctrl, wtsm_dp
//
// usage
//   request channel: drive req and raise start; the transfer happens at a rising edge
//   with start high and busy low. a load request writes one tile definition into the
//   table in that cycle: busy stays low and no result comes out.
//   a place request picks a definition for cell (cell_x, cell_z), matching the south
//   edge of the tile above and the east edge of the tile to the left, and raises busy.
//   result channel: result_valid is high for exactly one cycle with result; the
//   receiver cannot stall, so the result must be taken in that cycle. a new request
//   may be started in that same cycle.
//   a place request, with n = clamped definition count, fetches the neighbor edges
//   ((x*z) mod 19 finishes meanwhile), runs the count pass over the n entries, the
//   pick-mod-count subtract loop, the select pass, which stops at the chosen entry,
//   and finish; the result strobe follows. reduce and select are skipped when no
//   entry matches. the two scans share the single read port of the tile table.
//   configuration: apb register 0 holds definition_count; write only while idle.
//   reset: asynchronous, clears the count register, the controller and the
//   left-neighbor tile; the tile table and column memory are not cleared.
module wang_tile_scanline_matcher_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          start,
	output logic                          busy,
	input  wtsm_pkg::req_t                req,
	// result channel
	output logic                          result_valid,
	output wtsm_pkg::result_t             result,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wtsm_pkg::APB_AW-1:0]   paddr,
	input  logic [wtsm_pkg::APB_DW-1:0]   pwdata,
	output logic [wtsm_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	logic [wtsm_pkg::CNT_W-1:0] limit;
	wtsm_pkg::dp_cmd_t          cmd;
	wtsm_pkg::dp_stat_t         stat;

	// definition count register, clamped to the table size
	wtsm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.limit   (limit)
	);

	// sequencer: lookup of neighbors, count pass, reduce, select pass, finish
	wtsm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.req_type     (req.req_type),
		.stat         (stat),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	// tables, compare and arithmetic
	wtsm_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.limit  (limit),
		.stat   (stat),
		.result (result)
	);

endmodule

/* hdl/wtsm_regs.sv */
// wtsm_regs: apb register file holding the definition count
// depends on wtsm_pkg
module wtsm_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [wtsm_pkg::APB_AW-1:0]      paddr,
	input  logic [wtsm_pkg::APB_DW-1:0]      pwdata,
	output logic [wtsm_pkg::APB_DW-1:0]      prdata,
	output logic                             pready,
	output logic [wtsm_pkg::CNT_W-1:0]       limit
);

	logic [wtsm_pkg::CNT_W-1:0]     def_count_q;
	logic [wtsm_pkg::REG_IDX_W-1:0] reg_idx;
	logic                           wr_en;

	assign reg_idx = paddr[wtsm_pkg::APB_AW-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_count_q <= '0;
		end else if (wr_en && reg_idx == wtsm_pkg::REG_DEF_COUNT) begin
			def_count_q <= pwdata[wtsm_pkg::CNT_W-1:0];
		end
	end

	always_comb begin
		case (reg_idx)
			wtsm_pkg::REG_DEF_COUNT: begin
				prdata = wtsm_pkg::APB_DW'(def_count_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// clamp to table size
	assign limit = (def_count_q > wtsm_pkg::CNT_W'(wtsm_pkg::MAX_TILES)) ?
		wtsm_pkg::CNT_W'(wtsm_pkg::MAX_TILES) : def_count_q;

endmodule

/* hdl/wtsm_dp.sv */
// wtsm_dp: datapath with tile table, column memory, scan compare, count and mod units
// depends on wtsm_pkg
module wtsm_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wtsm_pkg::dp_cmd_t             cmd,
	input  wtsm_pkg::req_t                req,
	input  logic [wtsm_pkg::CNT_W-1:0]    limit,
	output wtsm_pkg::dp_stat_t            stat,
	output wtsm_pkg::result_t             result
);

	logic [wtsm_pkg::WORD_W-1:0]  tile_mem [wtsm_pkg::MAX_TILES];
	logic [wtsm_pkg::TILE_AW-1:0] row_mem  [wtsm_pkg::GRID_WIDTH];

	logic [wtsm_pkg::WORD_W-1:0]  tile_rd_q;
	logic [wtsm_pkg::TILE_AW-1:0] tile_rd_addr;
	logic [wtsm_pkg::TILE_AW-1:0] row_rd_q;
	logic [wtsm_pkg::TILE_AW-1:0] left_q;
	logic [wtsm_pkg::COL_AW-1:0]  col_q;
	logic                         x_zero_q;
	logic                         z_zero_q;
	logic [wtsm_pkg::COLOR_W-1:0] want_n_q;
	logic [wtsm_pkg::COLOR_W-1:0] want_w_q;

	logic [wtsm_pkg::CNT_W-1:0]   scan_idx_q;
	logic                         vld_s1;
	logic [wtsm_pkg::TILE_AW-1:0] idx_s1;
	logic                         issue;
	logic                         match;
	logic [wtsm_pkg::CNT_W-1:0]   count_q;
	logic [wtsm_pkg::CNT_W-1:0]   seen_q;
	logic                         found_q;
	logic [wtsm_pkg::TILE_AW-1:0] chosen_q;

	logic [wtsm_pkg::PROD_W-1:0]   prod_q;
	logic [wtsm_pkg::QUOT_W-1:0]   quot_q;
	logic [wtsm_pkg::PICK_W-1:0]   pick_q;
	logic [wtsm_pkg::STEP_W-1:0]   mod_cnt_q;
	logic [2*wtsm_pkg::PROD_W-1:0] recip_prod;
	logic [wtsm_pkg::PROD_W-1:0]   mod_rem;
	logic                          reduce_done;

	// tile table: one write port, one registered read port
	always_comb begin
		case (cmd.rd_sel)
			wtsm_pkg::RD_SEL_ABOVE: tile_rd_addr = row_rd_q;
			wtsm_pkg::RD_SEL_LEFT:  tile_rd_addr = left_q;
			default:                tile_rd_addr = scan_idx_q[wtsm_pkg::TILE_AW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_we) begin
			tile_mem[req.def_slot] <= {req.edge_west, req.edge_south,
				req.edge_east, req.edge_north};
		end
		tile_rd_q <= tile_mem[tile_rd_addr];
	end

	// column memory: tile last placed in each column
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			row_mem[col_q] <= chosen_q;
		end
		if (cmd.accept_place) begin
			row_rd_q <= row_mem[req.cell_x[wtsm_pkg::COL_AW-1:0]];
		end
	end

	// request and wanted pattern
	always_ff @(posedge clk) begin
		if (cmd.accept_place) begin
			col_q    <= req.cell_x[wtsm_pkg::COL_AW-1:0];
			x_zero_q <= (req.cell_x == '0);
			z_zero_q <= (req.cell_z == '0);
		end
		if (cmd.take_north) begin
			want_n_q <= z_zero_q ? '0 : tile_rd_q[3*wtsm_pkg::COLOR_W-1:2*wtsm_pkg::COLOR_W];
		end
		if (cmd.take_west) begin
			want_w_q <= x_zero_q ? '0 : tile_rd_q[2*wtsm_pkg::COLOR_W-1:wtsm_pkg::COLOR_W];
		end
	end

	assign issue = cmd.scan_run && (scan_idx_q < limit);
	assign match = vld_s1
		&& (want_n_q == '0 || want_n_q == tile_rd_q[wtsm_pkg::COLOR_W-1:0])
		&& (want_w_q == '0
			|| want_w_q == tile_rd_q[wtsm_pkg::WORD_W-1:3*wtsm_pkg::COLOR_W]);

	// scan over the table, count pass or select pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			count_q    <= '0;
			seen_q     <= '0;
			found_q    <= 1'b0;
			chosen_q   <= '0;
			left_q     <= '0;
		end else begin
			vld_s1 <= issue;
			idx_s1 <= scan_idx_q[wtsm_pkg::TILE_AW-1:0];
			if (cmd.accept_place) begin
				found_q  <= 1'b0;
				chosen_q <= '0;
			end
			if (cmd.scan_start) begin
				scan_idx_q <= '0;
				vld_s1     <= 1'b0;
				seen_q     <= '0;
				if (!cmd.sel_mode) begin
					count_q <= '0;
				end
			end else begin
				if (issue) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				if (match && !cmd.sel_mode) begin
					count_q <= count_q + 1'b1;
				end
				if (match && cmd.sel_mode && !found_q) begin
					if (seen_q == wtsm_pkg::CNT_W'(pick_q)) begin
						chosen_q <= idx_s1;
						found_q  <= 1'b1;
					end
					seen_q <= seen_q + 1'b1;
				end
			end
			if (cmd.finish) begin
				left_q <= chosen_q;
			end
		end
	end

	// (x*z) mod 19 by reciprocal multiply: the quotient is registered first, the remainder
	// is registered from it into pick, then pick mod count by repeated subtraction
	assign recip_prod  = (2*wtsm_pkg::PROD_W)'(prod_q)
		* (2*wtsm_pkg::PROD_W)'(wtsm_pkg::MOD_RECIP);
	assign mod_rem     = prod_q
		- wtsm_pkg::PROD_W'(quot_q) * wtsm_pkg::PROD_W'(wtsm_pkg::MOD_BASE);
	assign reduce_done = wtsm_pkg::CNT_W'(pick_q) < count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_cnt_q <= '0;
			pick_q    <= '0;
			prod_q    <= '0;
			quot_q    <= '0;
		end else if (cmd.accept_place) begin
			prod_q    <= wtsm_pkg::PROD_W'(req.cell_x) * wtsm_pkg::PROD_W'(req.cell_z);
			pick_q    <= '0;
			mod_cnt_q <= wtsm_pkg::STEP_W'(wtsm_pkg::MOD_STAGES);
		end else if (mod_cnt_q != '0) begin
			if (mod_cnt_q == wtsm_pkg::STEP_W'(wtsm_pkg::MOD_STAGES)) begin
				quot_q <= recip_prod[2*wtsm_pkg::PROD_W-1:wtsm_pkg::MOD_SHIFT];
			end else begin
				pick_q <= mod_rem[wtsm_pkg::PICK_W-1:0];
			end
			mod_cnt_q <= mod_cnt_q - 1'b1;
		end else if (cmd.reduce && !reduce_done) begin
			pick_q <= pick_q - count_q[wtsm_pkg::PICK_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result.chosen_tile <= chosen_q;
			result.match_found <= found_q;
		end
	end

	assign stat.scan_done   = !(scan_idx_q < limit) && !vld_s1;
	assign stat.count_zero  = (count_q == '0);
	assign stat.mod_done    = (mod_cnt_q == '0);
	assign stat.reduce_done = reduce_done;
	assign stat.hit         = found_q;

endmodule

/* hdl/wtsm_ctrl.sv */
// wtsm_ctrl: sequencing state machine for load and place requests
// depends on wtsm_pkg
module wtsm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  req_type,
	input  wtsm_pkg::dp_stat_t    stat,
	output wtsm_pkg::dp_cmd_t     cmd,
	output logic                  busy,
	output logic                  result_valid
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ABOVE,
		ST_NORTH,
		ST_WEST,
		ST_COUNT,
		ST_REDUCE,
		ST_SELECT,
		ST_DONE
	} state_t;

	state_t state_q;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = wtsm_pkg::RD_SEL_SCAN;
		case (state_q)
			ST_IDLE: begin
				cmd.load_we      = start && (req_type == wtsm_pkg::REQ_LOAD);
				cmd.accept_place = start && (req_type == wtsm_pkg::REQ_PLACE);
			end
			ST_ABOVE: begin
				cmd.rd_sel = wtsm_pkg::RD_SEL_ABOVE;
			end
			ST_NORTH: begin
				cmd.take_north = 1'b1;
				cmd.rd_sel     = wtsm_pkg::RD_SEL_LEFT;
			end
			ST_WEST: begin
				cmd.take_west  = 1'b1;
				cmd.scan_start = 1'b1;
			end
			ST_COUNT: begin
				cmd.scan_run = 1'b1;
			end
			ST_REDUCE: begin
				cmd.reduce     = 1'b1;
				cmd.scan_start = stat.reduce_done;
				cmd.sel_mode   = 1'b1;
			end
			ST_SELECT: begin
				cmd.scan_run = 1'b1;
				cmd.sel_mode = 1'b1;
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
			end
			default: begin
				cmd.finish = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start && req_type == wtsm_pkg::REQ_PLACE) begin
						state_q <= ST_ABOVE;
					end
				end
				ST_ABOVE: begin
					state_q <= ST_NORTH;
				end
				ST_NORTH: begin
					state_q <= ST_WEST;
				end
				ST_WEST: begin
					state_q <= ST_COUNT;
				end
				ST_COUNT: begin
					if (stat.scan_done && stat.count_zero) begin
						state_q <= ST_DONE;
					end else if (stat.scan_done && stat.mod_done) begin
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (stat.reduce_done) begin
						state_q <= ST_SELECT;
					end
				end
				ST_SELECT: begin
					if (stat.hit || stat.scan_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q      <= ST_IDLE;
					result_valid <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* hdl/wtsm_checker.sv */
// wtsm_checker: port-level assertions for the matcher core, bound to the top level
// depends on wtsm_pkg and wang_tile_scanline_matcher_core
module wtsm_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  wtsm_pkg::req_t                req,
	input  logic                          result_valid,
	input  wtsm_pkg::result_t             result
);

	// a place transfer always occupies the block
	a_place_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.req_type == wtsm_pkg::REQ_PLACE |=> busy)
		else $error("place transfer did not raise busy");

	// a load transfer neither occupies the block nor yields a result
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.req_type == wtsm_pkg::REQ_LOAD |=> !busy && !result_valid)
		else $error("load transfer disturbed the block");

	// a result arrives when the block goes idle and never twice in a row
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy && $past(busy) && !$past(result_valid))
		else $error("result strobe out of place");

	// no match forces tile zero
	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.match_found |-> result.chosen_tile == '0)
		else $error("unmatched result carries a nonzero tile");

endmodule

bind wang_tile_scanline_matcher_core wtsm_checker u_wtsm_checker (.*);

/* dv/wtsm_tile_checker.sv */
// wtsm_tile_checker: watches the request, result and apb channels of the tile matcher,
// predicts the chosen tile for every placement and compares it with the block's output
// depends on wtsm_pkg
module wtsm_tile_checker
	import wtsm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  req_t                req,
	input  logic                result_valid,
	input  result_t             result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	input  logic                pready,
	output int                  fail_count,
	output int                  pending,
	output int                  n_results,
	output int                  n_found
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_REPORTS = 40;

	typedef struct {
		result_t            res;
		logic [X_W-1:0]     x;
		logic [Z_W-1:0]     z;
	} placed_cell_t;

	// shadow copy of the block state
	logic [WORD_W-1:0]  tile_defs [MAX_TILES];
	logic [TILE_AW-1:0] tile_above [GRID_WIDTH];
	logic [TILE_AW-1:0] tile_left;
	logic [CNT_W-1:0]   def_count;

	placed_cell_t       placements [$];

	initial begin
		fail_count = 0;
		n_results  = 0;
		n_found    = 0;
	end

	task automatic report_mismatch(input string msg);
		if (fail_count < MAX_REPORTS)
			$display("%0t ns: mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	// a wanted colour of zero matches anything
	function automatic bit fits(input logic [WORD_W-1:0] word, input logic [COLOR_W-1:0] want_n,
			input logic [COLOR_W-1:0] want_w);
		if (want_n != 0 && want_n != word[COLOR_W-1:0])
			return 0;
		if (want_w != 0 && want_w != word[4*COLOR_W-1:3*COLOR_W])
			return 0;
		return 1;
	endfunction

	function automatic result_t pick_tile(input logic [X_W-1:0] x, input logic [Z_W-1:0] z);
		int               limit;
		int               hits;
		int               target;
		int               seen;
		logic [COLOR_W-1:0] want_n;
		logic [COLOR_W-1:0] want_w;
		result_t          r;
		limit  = (def_count > MAX_TILES) ? MAX_TILES : int'(def_count);
		want_n = (z == 0) ? '0 : tile_defs[tile_above[int'(x) % GRID_WIDTH]][3*COLOR_W-1:2*COLOR_W];
		want_w = (x == 0) ? '0 : tile_defs[tile_left][2*COLOR_W-1:COLOR_W];
		r      = '0;
		hits   = 0;
		for (int i = 0; i < limit; i++)
			if (fits(tile_defs[i], want_n, want_w))
				hits++;
		if (hits != 0) begin
			target = ((int'(x) * int'(z)) % MOD_BASE) % hits;
			seen   = 0;
			for (int i = 0; i < limit; i++) begin
				if (fits(tile_defs[i], want_n, want_w)) begin
					if (seen == target) begin
						r.chosen_tile = TILE_AW'(i);
						r.match_found = 1'b1;
						break;
					end
					seen++;
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		placed_cell_t exp_cell;
		result_t      res;
		if (!arst_n) begin
			tile_left = '0;
			def_count = '0;
			placements.delete();
			pending <= 0;
		end else begin
			if (result_valid) begin
				n_results++;
				if (result.match_found === 1'b1)
					n_found++;
				if (placements.size() == 0) begin
					report_mismatch($sformatf("result tile %0d with no placement waiting",
						result.chosen_tile));
				end else begin
					exp_cell = placements.pop_front();
					if (result.chosen_tile !== exp_cell.res.chosen_tile)
						report_mismatch($sformatf("cell (%0d,%0d) chosen_tile %0d, expected %0d",
							exp_cell.x, exp_cell.z, result.chosen_tile,
							exp_cell.res.chosen_tile));
					if (result.match_found !== exp_cell.res.match_found)
						report_mismatch($sformatf("cell (%0d,%0d) match_found %0b, expected %0b",
							exp_cell.x, exp_cell.z, result.match_found,
							exp_cell.res.match_found));
				end
			end
			if (start && !busy) begin
				if (req.req_type == REQ_LOAD) begin
					if (int'(req.def_slot) < MAX_TILES)
						tile_defs[req.def_slot] = {req.edge_west, req.edge_south,
							req.edge_east, req.edge_north};
				end else begin
					res = pick_tile(req.cell_x, req.cell_z);
					tile_above[int'(req.cell_x) % GRID_WIDTH] = res.chosen_tile;
					tile_left = res.chosen_tile;
					placements.push_back('{res, req.cell_x, req.cell_z});
				end
			end
			if (psel && penable && pwrite && pready && paddr[APB_AW-1:2] == REG_DEF_COUNT)
				def_count = pwdata[CNT_W-1:0];
			pending <= placements.size();
		end
	end

endmodule

/* dv/tb_wang_tile_scanline_matcher_core.sv */
// tb_wang_tile_scanline_matcher_core: stimulus and verdict for the wang tile matcher;
// loads tile tables, places cells in row-major scans and noise, under several counts
// depends on wtsm_pkg, wtsm_tile_checker and the rtl of wang_tile_scanline_matcher_core
module tb_wang_tile_scanline_matcher_core;
	timeunit 1ns;
	timeprecision 1ps;
	import wtsm_pkg::*;

	localparam int ITEM_TARGET   = 1850;
	localparam int N_PHASES      = 8;
	// covers a placement over a full table
	localparam int DRAIN_CYCLES  = 160;
	// a load does not make the block busy
	localparam int LOAD_SETTLE   = 8;
	localparam int CYCLE_LIMIT   = 4_000_000;

	logic                clk     = 1'b0;
	logic                arst_n  = 1'b0;
	logic                start   = 1'b0;
	logic                busy;
	req_t                req     = '0;
	logic                result_valid;
	result_t             result;
	logic                psel    = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite  = 1'b0;
	logic [APB_AW-1:0]   paddr   = '0;
	logic [APB_DW-1:0]   pwdata  = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	int                  fail_count;
	int                  pending;
	int                  n_results;
	int                  n_found;

	int unsigned         cycle_count = 0;
	int                  n_loads     = 0;
	int                  n_places    = 0;
	int                  n_settings  = 0;
	// percent of cycles in which the sender holds back
	int                  idle_pct    = 0;
	int                  idle_mix [3] = '{0, 74, 10};

	always #5 clk = ~clk;

	wang_tile_scanline_matcher_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.result_valid (result_valid),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	wtsm_tile_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.result_valid (result_valid),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.fail_count   (fail_count),
		.pending      (pending),
		.n_results    (n_results),
		.n_found      (n_found)
	);

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	// mostly a small palette so that edges match often, now and then any colour
	function automatic logic [COLOR_W-1:0] colour();
		if ($urandom_range(4) == 0)
			return COLOR_W'($urandom);
		return COLOR_W'($urandom_range(3));
	endfunction

	// fields a load does not use carry random junk
	function automatic req_t load_item(input int slot, input logic [COLOR_W-1:0] n,
			input logic [COLOR_W-1:0] e, input logic [COLOR_W-1:0] s,
			input logic [COLOR_W-1:0] w);
		req_t r;
		r            = req_t'({$urandom, $urandom, $urandom});
		r.req_type   = REQ_LOAD;
		r.def_slot   = TILE_AW'(slot);
		r.edge_north = n;
		r.edge_east  = e;
		r.edge_south = s;
		r.edge_west  = w;
		return r;
	endfunction

	// fields a placement does not use carry random junk
	function automatic req_t place_item(input int x, input int z);
		req_t r;
		r          = req_t'({$urandom, $urandom, $urandom});
		r.req_type = REQ_PLACE;
		r.cell_x   = X_W'(x);
		r.cell_z   = Z_W'(z);
		return r;
	endfunction

	// one request transfer; start stays high into the next item unless a gap is drawn
	task automatic send(input req_t item);
		int gap;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			// occasional long gap so that start also comes back around the end of busy
			if ($urandom_range(3) == 0) begin
				gap = $urandom_range(1, DRAIN_CYCLES);
				repeat (gap) @(posedge clk);
			end else begin
				do @(posedge clk); while ($urandom_range(99) < idle_pct);
			end
		end
		start <= 1'b1;
		req   <= item;
		do @(posedge clk); while (busy);
		if (item.req_type == REQ_LOAD)
			n_loads++;
		else
			n_places++;
	endtask

	task automatic random_load();
		send(load_item($urandom_range(MAX_TILES - 1), colour(), colour(), colour(), colour()));
	endtask

	// sender pauses until every placement has its result and the block is idle
	task automatic drain(input int settle);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// apb write of definition_count: setup then access; upper data bits are junk
	task automatic write_count(input logic [CNT_W-1:0] value);
		logic [APB_DW-1:0] data;
		data             = $urandom;
		data[CNT_W-1:0]  = value;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_DEF_COUNT, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		n_settings++;
	endtask

	// count per phase: full table, above the table size, tiny tables, a mid-size table, random
	function automatic logic [CNT_W-1:0] phase_count(input int ph);
		case (ph)
			0:       return CNT_W'(MAX_TILES);
			1:       return '1;
			2:       return CNT_W'(1);
			3:       return CNT_W'(3);
			4:       return CNT_W'(MAX_TILES + 1);
			5:       return CNT_W'($urandom_range(127));
			6:       return CNT_W'(16);
			default: return CNT_W'($urandom_range(2, MAX_TILES));
		endcase
	endfunction

	initial begin
		int budget;
		int z0;
		int span;
		int rows;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: a single definition whose east and south edges match nothing it offers
		write_count(1);
		send(load_item(0, 8'h05, 8'h11, 8'h22, 8'h33));
		send(place_item(0, 0));          // top-left corner, everything wild
		send(place_item(1, 0));          // top row, west wants 0x11, no match
		send(place_item(0, 1));          // left column, north wants 0x22, no match
		drain(LOAD_SETTLE);
		write_count(0);
		send(place_item(2, 0));          // empty table
		drain(LOAD_SETTLE);
		write_count(4);
		send(load_item(1, 8'hff, 8'hff, 8'hff, 8'hff));
		send(load_item(2, 8'h22, 8'h11, 8'h22, 8'h11));
		send(load_item(3, 8'h00, 8'h00, 8'h00, 8'h00));
		send(load_item(MAX_TILES - 1, 8'hff, 8'hff, 8'hff, 8'hff));
		send(place_item(63, 0));         // last column
		send(place_item(1, 1));
		send(place_item(2, 4095));       // last row
		send(place_item(63, 4095));      // largest product
		send(place_item(0, 2));

		// fill the rest of the table so any count reads written entries only
		for (int s = 4; s < MAX_TILES - 1; s++)
			send(load_item(s, colour(), colour(), colour(), colour()));

		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain(LOAD_SETTLE);
			idle_pct = idle_mix[ph % 3];
			write_count(phase_count(ph));
			// one full top row so every column has a tile above it
			if (ph == 0)
				for (int x = 0; x < GRID_WIDTH; x++)
					send(place_item(x, 0));
			budget = n_loads + n_places + (ITEM_TARGET - n_loads - n_places) / (N_PHASES - ph);
			while (n_loads + n_places < budget) begin
				case ($urandom_range(9))
					0, 1, 2, 3, 4, 5, 6: begin
						// row-major scan with random content and the odd reload in between
						z0   = $urandom_range(4095);
						span = ($urandom_range(3) == 0) ? $urandom_range(1, GRID_WIDTH)
							: $urandom_range(1, 12);
						rows = $urandom_range(1, 3);
						for (int r = 0; r < rows; r++)
							for (int x = 0; x < span; x++) begin
								if ($urandom_range(9) == 0)
									random_load();
								send(place_item(x, (z0 + r) % 4096));
							end
					end
					7, 8: begin
						// out-of-order placement
						send(place_item($urandom_range(63), $urandom_range(4095)));
					end
					default: begin
						repeat ($urandom_range(1, 4)) random_load();
					end
				endcase
				if ($urandom_range(49) == 0)
					drain(0);
			end
		end

		drain(DRAIN_CYCLES);
		$display("run covered %0d tile loads, %0d placements and %0d count settings",
			n_loads, n_places, n_settings);
		$display("%0d placements found a tile, %0d fell back to tile 0",
			n_found, n_results - n_found);
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
